[design/rau_pkg.sv]
// Package for the rational arithmetic unit: operation and status codes,
// controller state type and controller/datapath command and status structs.
package rau_pkg;

  localparam int unsigned WordBitsDefault = 32;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_GSHIFT,
    S_GSTRIP,
    S_GLOOP,
    S_DIVSETUP,
    S_DIV,
    S_CHECK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic gshift;
    logic gstrip;
    logic gloop;
    logic divsetup;
    logic divstep;
    logic check;
  } cmd_t;

  typedef struct packed {
    logic early;
    logic both_even;
    logic x_odd;
    logic y_zero;
    logic div_last;
  } stat_t;

endpackage

[design/rau_ctrl.sv]
// Controller for the rational arithmetic unit: sequences load, products,
// binary GCD and restoring division. Depends on rau_pkg.
module rau_ctrl
  import rau_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o,
  output logic  done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_GSHIFT;
      end
      S_GSHIFT: begin
        if (stat_i.early) begin
          state_d = S_DONE;
        end else if (stat_i.both_even) begin
          cmd_o.gshift = 1'b1;
        end else begin
          state_d = S_GSTRIP;
        end
      end
      S_GSTRIP: begin
        if (stat_i.x_odd) begin
          state_d = S_GLOOP;
        end else begin
          cmd_o.gstrip = 1'b1;
        end
      end
      S_GLOOP: begin
        if (stat_i.y_zero) begin
          state_d = S_DIVSETUP;
        end else begin
          cmd_o.gloop = 1'b1;
        end
      end
      S_DIVSETUP: begin
        cmd_o.divsetup = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.divstep = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[design/rau_dp.sv]
// Datapath for the rational arithmetic unit: normalization, cross products,
// binary GCD and two restoring dividers that share one divisor. Depends on rau_pkg.
module rau_dp
  import rau_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDefault
) (
  input  logic                 clk_i,
  input  cmd_t                 cmd_i,
  input  logic [2:0]           operation_i,
  input  logic [31:0]          a_num_i,
  input  logic [31:0]          a_den_i,
  input  logic [31:0]          b_num_i,
  input  logic [31:0]          b_den_i,
  output stat_t                stat_o,
  output logic signed [31:0]   res_num_o,
  output logic [30:0]          res_den_o,
  output logic                 less_o,
  output logic                 equal_o,
  output logic [1:0]           status_o
);

  localparam int unsigned PW = 2 * WORD_BITS;
  localparam int unsigned KW = $clog2(PW + 1);

  logic [2:0]              op_q;
  logic [WORD_BITS:0]      an_q, ad_q, bn_q, bd_q;
  logic                    an_neg_q, bn_neg_q;
  logic [PW-1:0]           p1_q, p2_q, pd_q;
  logic [PW-1:0]           num_q, den_q;
  logic                    neg_q;
  logic [PW-1:0]           x_q, y_q;
  logic [KW-1:0]           k_q, cnt_q;
  logic [PW-1:0]           g_q;
  logic [PW-1:0]           qn_q, rn_q, qd_q, rd_q;
  logic                    early_q;
  logic signed [31:0]      res_num_q;
  logic [30:0]             res_den_q;
  logic                    less_q, equal_q;
  logic [1:0]              status_q;

  logic signed [WORD_BITS-1:0] an_w, ad_w, bn_w, bd_w;
  logic signed [WORD_BITS:0]   an_n, bn_n, ad_n, bd_n;
  logic [PW:0]                 rn_sh, rd_sh;
  logic [PW:0]                 rn_sub, rd_sub;
  logic [PW-1:0]               lim_pos, lim_neg;
  logic                        ovf;
  logic [PW-1:0]               sum_mag;
  logic                        sum_neg, l_neg, r_neg;

  function automatic logic signed [WORD_BITS-1:0] an_i_trunc(input logic [31:0] v);
    an_i_trunc = v[WORD_BITS-1:0];
  endfunction

  assign an_w = an_i_trunc(a_num_i);
  assign ad_w = an_i_trunc(a_den_i);
  assign bn_w = an_i_trunc(b_num_i);
  assign bd_w = an_i_trunc(b_den_i);

  always_comb begin
    an_n = {an_w[WORD_BITS-1], an_w};
    bn_n = {bn_w[WORD_BITS-1], bn_w};
    ad_n = {ad_w[WORD_BITS-1], ad_w};
    bd_n = {bd_w[WORD_BITS-1], bd_w};
    if (ad_w[WORD_BITS-1]) begin
      an_n = -an_n;
      ad_n = -ad_n;
    end
    if (bd_w[WORD_BITS-1]) begin
      bn_n = -bn_n;
      bd_n = -bd_n;
    end
    if (operation_i == OP_SUB || operation_i == OP_CMP) begin
      bn_n = -bn_n;
    end
  end

  always_comb begin
    l_neg = an_neg_q && (p1_q != '0);
    r_neg = bn_neg_q && (p2_q != '0);
    if (l_neg == r_neg) begin
      sum_neg = l_neg;
      sum_mag = p1_q + p2_q;
    end else if (p1_q >= p2_q) begin
      sum_neg = l_neg;
      sum_mag = p1_q - p2_q;
    end else begin
      sum_neg = r_neg;
      sum_mag = p2_q - p1_q;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
  end

  assign rn_sh  = {rn_q, qn_q[PW-1]};
  assign rd_sh  = {rd_q, qd_q[PW-1]};
  assign rn_sub = rn_sh - {1'b0, g_q};
  assign rd_sub = rd_sh - {1'b0, g_q};
  assign lim_pos = (PW'(1) << (WORD_BITS - 1)) - PW'(1);
  assign lim_neg = PW'(1) << (WORD_BITS - 1);
  assign ovf = (qd_q > lim_pos) || (neg_q ? (qn_q > lim_neg) : (qn_q > lim_pos));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= operation_i;
      an_neg_q <= an_n[WORD_BITS];
      bn_neg_q <= bn_n[WORD_BITS];
      an_q     <= an_n[WORD_BITS] ? -an_n : an_n;
      bn_q     <= bn_n[WORD_BITS] ? -bn_n : bn_n;
      ad_q     <= ad_n;
      bd_q     <= bd_n;
      less_q   <= 1'b0;
      equal_q  <= 1'b0;
      res_num_q <= '0;
      res_den_q <= 31'd1;
      if (ad_w == '0 || bd_w == '0) begin
        status_q <= ST_ZERO_DEN;
        early_q  <= 1'b1;
      end else if (operation_i == OP_DIV && bn_w == '0) begin
        status_q <= ST_DIV_ZERO;
        early_q  <= 1'b1;
      end else if (operation_i != OP_ADD && operation_i != OP_SUB &&
                   operation_i != OP_MUL && operation_i != OP_DIV &&
                   operation_i != OP_CMP) begin
        status_q <= ST_OK;
        early_q  <= 1'b1;
      end else begin
        status_q <= ST_OK;
        early_q  <= 1'b0;
      end
    end
    if (cmd_i.mul) begin
      case (op_q)
        OP_MUL: begin
          p1_q <= PW'(an_q) * PW'(bn_q);
          p2_q <= '0;
          pd_q <= PW'(ad_q) * PW'(bd_q);
          bn_neg_q <= 1'b0;
          an_neg_q <= an_neg_q ^ bn_neg_q;
        end
        OP_DIV: begin
          p1_q <= PW'(an_q) * PW'(bd_q);
          p2_q <= '0;
          pd_q <= PW'(ad_q) * PW'(bn_q);
          bn_neg_q <= 1'b0;
          an_neg_q <= an_neg_q ^ bn_neg_q;
        end
        default: begin
          p1_q <= PW'(an_q) * PW'(bd_q);
          p2_q <= PW'(bn_q) * PW'(ad_q);
          pd_q <= PW'(ad_q) * PW'(bd_q);
        end
      endcase
    end
    if (cmd_i.sum) begin
      num_q <= sum_mag;
      neg_q <= sum_neg;
      den_q <= pd_q;
      x_q   <= sum_mag;
      y_q   <= pd_q;
      k_q   <= '0;
      if (!early_q && op_q == OP_CMP) begin
        early_q <= 1'b1;
        equal_q <= (sum_mag == '0);
        less_q  <= sum_neg;
      end else if (sum_mag == '0) begin
        early_q <= 1'b1;
      end
    end
    if (cmd_i.gshift) begin
      x_q <= x_q >> 1;
      y_q <= y_q >> 1;
      k_q <= k_q + KW'(1);
    end
    if (cmd_i.gstrip) begin
      x_q <= x_q >> 1;
    end
    if (cmd_i.gloop) begin
      if (!y_q[0]) begin
        y_q <= y_q >> 1;
      end else if (x_q > y_q) begin
        x_q <= y_q;
        y_q <= x_q - y_q;
      end else begin
        y_q <= y_q - x_q;
      end
    end
    if (cmd_i.divsetup) begin
      g_q   <= x_q << k_q;
      qn_q  <= num_q;
      qd_q  <= den_q;
      rn_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.divstep) begin
      cnt_q <= cnt_q + KW'(1);
      if (!rn_sub[PW]) begin
        rn_q <= rn_sub[PW-1:0];
        qn_q <= {qn_q[PW-2:0], 1'b1};
      end else begin
        rn_q <= rn_sh[PW-1:0];
        qn_q <= {qn_q[PW-2:0], 1'b0};
      end
      if (!rd_sub[PW]) begin
        rd_q <= rd_sub[PW-1:0];
        qd_q <= {qd_q[PW-2:0], 1'b1};
      end else begin
        rd_q <= rd_sh[PW-1:0];
        qd_q <= {qd_q[PW-2:0], 1'b0};
      end
    end
    if (cmd_i.check) begin
      if (ovf) begin
        status_q <= ST_OVERFLOW;
      end else begin
        res_num_q <= 32'(signed'(neg_q ? -qn_q[WORD_BITS-1:0] : qn_q[WORD_BITS-1:0]));
        res_den_q <= 31'(qd_q[WORD_BITS-2:0]);
      end
    end
  end

  assign stat_o.early     = early_q;
  assign stat_o.both_even = !x_q[0] && !y_q[0];
  assign stat_o.x_odd     = x_q[0];
  assign stat_o.y_zero    = (y_q == '0);
  assign stat_o.div_last  = (cnt_q == KW'(PW - 1));

  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign less_o    = less_q;
  assign equal_o   = equal_q;
  assign status_o  = status_q;

endmodule

[design/rational_arithmetic_unit.sv]
// Rational arithmetic unit: one transaction at a time, busy from accept to done.
// Errors, compare and zero results skip from the GCD shift state straight to done;
// otherwise the binary GCD, both divisions and an overflow check run before done_o.
// A new transaction is taken only once the unit is idle again; the receiver cannot
// stall, the result is shown for one cycle with done_o.
// Reset (rst_ni, async, active low) returns the controller to idle.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  input  logic [2:0]         operation_i,
  input  logic [31:0]        a_num_i,
  input  logic [31:0]        a_den_i,
  input  logic [31:0]        b_num_i,
  input  logic [31:0]        b_den_i,
  output logic signed [31:0] res_num_o,
  output logic [30:0]        res_den_o,
  output logic               less_o,
  output logic               equal_o,
  output logic [1:0]         status_o
);

  cmd_t  cmd;
  stat_t stat;

  rau_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  rau_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .operation_i(operation_i),
    .a_num_i    (a_num_i),
    .a_den_i    (a_den_i),
    .b_num_i    (b_num_i),
    .b_den_i    (b_den_i),
    .stat_o     (stat),
    .res_num_o  (res_num_o),
    .res_den_o  (res_den_o),
    .less_o     (less_o),
    .equal_o    (equal_o),
    .status_o   (status_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy)
    else $error("done outside busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (less_o || equal_o) |-> status_o == ST_OK && res_num_o == 0)
    else $error("compare flags with payload");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> res_num_o == 0 && res_den_o == 31'd1)
    else $error("error result not cleared");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("done longer than one cycle");

endmodule

[bench/rational_arithmetic_unit_checker.sv]
`timescale 1ns / 1ps
// Checker for the rational arithmetic unit: predicts each transaction from the
// inputs accepted on start/busy and compares the done_o strobe. Uses rau_pkg.
module rational_arithmetic_unit_checker
  import rau_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic               done_o,
  input  logic [2:0]         operation_i,
  input  logic [31:0]        a_num_i,
  input  logic [31:0]        a_den_i,
  input  logic [31:0]        b_num_i,
  input  logic [31:0]        b_den_i,
  input  logic signed [31:0] res_num_o,
  input  logic [30:0]        res_den_o,
  input  logic               less_o,
  input  logic               equal_o,
  input  logic [1:0]         status_o,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic        lt;
    logic        eq;
    status_e     st;
  } fraction_t;

  fraction_t expected_q[$];

  function automatic fraction_t make_fraction(logic [31:0] n, logic [30:0] d,
                                              logic lt, logic eq, status_e st);
    fraction_t f;
    f.num = n;
    f.den = d;
    f.lt  = lt;
    f.eq  = eq;
    f.st  = st;
    return f;
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_t predict_fraction(logic [2:0] op, logic signed [31:0] an_w,
                                                 logic signed [31:0] ad_w,
                                                 logic signed [31:0] bn_w,
                                                 logic signed [31:0] bd_w);
    longint an, ad, bn, bd, d;
    logic signed [65:0] n;
    logic [63:0] nm, dm, gm;
    logic neg;
    an = an_w;
    ad = ad_w;
    bn = bn_w;
    bd = bd_w;
    if (ad == 0 || bd == 0) return make_fraction(0, 1, 0, 0, ST_ZERO_DEN);
    if (ad < 0) begin
      ad = -ad;
      an = -an;
    end
    if (bd < 0) begin
      bd = -bd;
      bn = -bn;
    end
    case (op)
      OP_ADD: begin
        n = 66'(an) * 66'(bd) + 66'(bn) * 66'(ad);
        d = ad * bd;
      end
      OP_SUB: begin
        n = 66'(an) * 66'(bd) - 66'(bn) * 66'(ad);
        d = ad * bd;
      end
      OP_MUL: begin
        n = 66'(an) * 66'(bn);
        d = ad * bd;
      end
      OP_DIV: begin
        if (bn == 0) return make_fraction(0, 1, 0, 0, ST_DIV_ZERO);
        n = 66'(an) * 66'(bd);
        d = ad * bn;
        if (d < 0) begin
          d = -d;
          n = -n;
        end
      end
      OP_CMP: return make_fraction(0, 1, an * bd < bn * ad, an * bd == bn * ad, ST_OK);
      default: return make_fraction(0, 1, 0, 0, ST_OK);
    endcase
    if (n == 0) return make_fraction(0, 1, 0, 0, ST_OK);
    neg = n < 0;
    nm = neg ? 64'(-n) : 64'(n);
    dm = 64'(d);
    gm = gcd64(nm, dm);
    nm = nm / gm;
    dm = dm / gm;
    if (dm > 64'h7fff_ffff || (neg ? nm > 64'h8000_0000 : nm > 64'h7fff_ffff))
      return make_fraction(0, 1, 0, 0, ST_OVERFLOW);
    return make_fraction(neg ? 32'(-nm) : nm[31:0], dm[30:0], 0, 0, ST_OK);
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    fraction_t want;
    if (!rst_ni) begin
      fail_count <= 0;
    end else begin
      if (start && !busy)
        expected_q.push_back(predict_fraction(operation_i, a_num_i, a_den_i, b_num_i,
                                              b_den_i));
      if (done_o) begin
        if (expected_q.size() == 0) begin
          $error("result with no transaction outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (res_num_o !== want.num || res_den_o !== want.den || less_o !== want.lt ||
              equal_o !== want.eq || status_o !== want.st) begin
            fail_count <= fail_count + 1;
            if (res_num_o !== want.num)
              $error("res_num expected %0d actual %0d", $signed(want.num), res_num_o);
            if (res_den_o !== want.den)
              $error("res_den expected %0d actual %0d", want.den, res_den_o);
            if (less_o !== want.lt) $error("less expected %0b actual %0b", want.lt, less_o);
            if (equal_o !== want.eq) $error("equal expected %0b actual %0b", want.eq, equal_o);
            if (status_o !== want.st)
              $error("status expected %0d actual %0d", want.st, status_o);
          end
        end
      end
    end
  end

endmodule

[bench/rational_arithmetic_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the rational arithmetic unit: clock, reset, directed and
// random stimulus, verdict. Depends on rau_pkg, rational_arithmetic_unit and its checker.
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam int CycleLimit = 5_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               done_o;
  logic [2:0]         operation_i = '0;
  logic [31:0]        a_num_i = '0;
  logic [31:0]        a_den_i = 32'd1;
  logic [31:0]        b_num_i = '0;
  logic [31:0]        b_den_i = 32'd1;
  logic signed [31:0] res_num_o;
  logic [30:0]        res_den_o;
  logic               less_o;
  logic               equal_o;
  logic [1:0]         status_o;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  logic               calm = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rational_arithmetic_unit i_dut (.*);
  rational_arithmetic_unit_checker i_checker (.*);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 20)) - 10);
      3: return $urandom;
      4: return 32'($urandom_range(0, 65535)) * 32'($urandom_range(0, 3) * 2 + 1);
      default: return 32'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  task automatic send_fraction_op(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                                  logic [31:0] bn, logic [31:0] bd);
    logic ready;
    ready = 1'b0;
    while (!calm && $urandom_range(0, 99) < 18) @(posedge clk_i);
    start       <= 1'b1;
    operation_i <= op;
    a_num_i     <= an;
    a_den_i     <= ad;
    b_num_i     <= bn;
    b_den_i     <= bd;
    while (!ready) begin
      @(negedge clk_i);
      ready = !busy;
      @(posedge clk_i);
    end
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] bd;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_fraction_op(OP_ADD, 1, 2, 1, 3);
    send_fraction_op(OP_SUB, 1, 2, 1, 2);
    send_fraction_op(OP_MUL, -3, 4, 8, -9);
    send_fraction_op(OP_DIV, 1, 2, 3, -4);
    send_fraction_op(OP_DIV, 5, 7, 0, 3);
    send_fraction_op(OP_CMP, 1, 3, 2, 6);
    send_fraction_op(OP_CMP, -1, 3, 1, 3);
    send_fraction_op(OP_CMP, 1, 3, -1, 3);
    send_fraction_op(OP_ADD, 1, 0, 1, 2);
    send_fraction_op(OP_DIV, 1, 2, 0, 0);
    send_fraction_op(OP_CMP, 1, 2, 1, 0);
    send_fraction_op(3'd5, 1, 2, 1, 3);
    send_fraction_op(3'd6, 1, 0, 1, 3);
    send_fraction_op(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_fraction_op(OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
    send_fraction_op(OP_MUL, 32'h8000_0000, 1, 1, 1);
    send_fraction_op(OP_MUL, 32'h8000_0000, 32'hffff_ffff, 1, 1);
    send_fraction_op(OP_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 32'h7fff_ffff);
    send_fraction_op(OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_fraction_op(OP_DIV, 1, 32'h7fff_ffff, 1, 32'h7fff_ffff);
    send_fraction_op(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_fraction_op(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_fraction_op(OP_ADD, 0, 5, 0, -7);
    send_fraction_op(OP_MUL, 0, 32'h8000_0000, 32'h7fff_ffff, 3);
    for (int i = 0; i < 1500; i++) begin
      calm = (i >= 600 && i < 800);
      bd = pick_word();
      if ($urandom_range(0, 19) != 0 && bd == 0) bd = 1;
      send_fraction_op(3'($urandom_range(0, 4) == 0 ? $urandom_range(0, 7)
                                                    : $urandom_range(0, 4)),
                       pick_word(), $urandom_range(0, 19) == 0 ? 32'd0 : pick_word() | 1,
                       pick_word(), bd);
    end
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
